@@ hw/rtl/shc_pkg.sv @@
package shc_pkg;

	localparam int DEF_MAX_SITES = 16;

	localparam int COL_W      = 16;
	localparam int VAL_W      = 22;
	localparam int COEF_W     = 16;
	localparam int NSITE_W    = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_TDATA_W = ((COL_W + VAL_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SITES     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_BOUNDARY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUPLING_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUPLING_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COUPLING_Z    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_X       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_Z       = 3'd6;

	localparam logic [NSITE_W-1:0]       RST_NUM_SITES = 5'd1;
	localparam logic signed [COEF_W-1:0] RST_COEF      = 16'sd256;

	// queue word layout, lowest bit up: row, error, diagonal value, diagonal enable,
	// flip vector, bond vector, antiparallel vector
	localparam int OFS_ERR  = COL_W;
	localparam int OFS_DIAG = COL_W + 1;
	localparam int OFS_DEN  = COL_W + 1 + VAL_W;
	localparam int OFS_VEC  = COL_W + 2 + VAL_W;

	typedef struct packed {
		logic [NSITE_W-1:0]       num_sites;
		logic                     open_boundary;
		logic signed [COEF_W-1:0] coupling_x;
		logic signed [COEF_W-1:0] coupling_y;
		logic signed [COEF_W-1:0] coupling_z;
		logic signed [COEF_W-1:0] field_x;
		logic signed [COEF_W-1:0] field_z;
	} cfg_t;

	function automatic int entry_w(input int sites);
		return OFS_VEC + 3 * sites;
	endfunction

	// zero sites counts as one, anything above the limit as the limit
	function automatic logic [NSITE_W-1:0] clamp_len(input logic [NSITE_W-1:0] n,
		input logic [NSITE_W-1:0] lim);
		logic [NSITE_W-1:0] r;
		r = n;
		if (n == '0) r = NSITE_W'(1);
		else if (n > lim) r = lim;
		return r;
	endfunction

endpackage

@@ hw/rtl/spin_chain_hamiltonian_row_gen.sv @@
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[15:0] row_index
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata column_index, entry_value; tuser; tlast
// cfg       in   cfg_valid/cfg_ready           cfg_index register, cfg_data value
//
// a row produces one result word per entry: the diagonal, up to num_sites single
// flips and up to num_sites bond flips, so 1 to 2*num_sites+1 words, sent by the
// one-word-per-cycle expander in the back end while m_axis is not stalled.
// the front end takes a row every cycle unless the two-deep queue between the parts is full.
// arst_n clears all handshake state and loads the register defaults.
// cfg_ready is always high; stalls on m_axis back up through the queue to s_axis.
module spin_chain_hamiltonian_row_gen #(
	parameter int MAX_SITES = shc_pkg::DEF_MAX_SITES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [shc_pkg::COL_W-1:0]         s_axis_tdata,   // row_index
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [shc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // column_index, entry_value
	output logic [shc_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,   // entry_valid, row_error
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [shc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [shc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import shc_pkg::*;

	localparam int EW = entry_w(MAX_SITES);

	cfg_t          cfg_q;
	logic          q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
	logic [EW-1:0] q_push_data, q_pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_sites     <= RST_NUM_SITES;
			cfg_q.open_boundary <= 1'b0;
			cfg_q.coupling_x    <= RST_COEF;
			cfg_q.coupling_y    <= RST_COEF;
			cfg_q.coupling_z    <= RST_COEF;
			cfg_q.field_x       <= RST_COEF;
			cfg_q.field_z       <= RST_COEF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NUM_SITES:     cfg_q.num_sites     <= cfg_data[NSITE_W-1:0];
				REG_OPEN_BOUNDARY: cfg_q.open_boundary <= cfg_data[0];
				REG_COUPLING_X:    cfg_q.coupling_x    <= $signed(cfg_data);
				REG_COUPLING_Y:    cfg_q.coupling_y    <= $signed(cfg_data);
				REG_COUPLING_Z:    cfg_q.coupling_z    <= $signed(cfg_data);
				REG_FIELD_X:       cfg_q.field_x       <= $signed(cfg_data);
				REG_FIELD_Z:       cfg_q.field_z       <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	shc_front #(.MAX_SITES(MAX_SITES)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push_valid    (q_push_valid),
		.push_ready    (q_push_ready),
		.push_data     (q_push_data)
	);

	shc_fifo #(.WIDTH(EW), .DEPTH(2)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	shc_back #(.MAX_SITES(MAX_SITES)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.pop_valid     (q_pop_valid),
		.pop_ready     (q_pop_ready),
		.pop_data      (q_pop_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ hw/rtl/shc_fifo.sv @@
module shc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ hw/rtl/shc_front.sv @@
module shc_front #(
	parameter int MAX_SITES = shc_pkg::DEF_MAX_SITES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  shc_pkg::cfg_t                        cfg,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [shc_pkg::COL_W-1:0]            s_axis_tdata,
	output logic                                 push_valid,
	input  logic                                 push_ready,
	output logic [shc_pkg::entry_w(MAX_SITES)-1:0] push_data
);

	import shc_pkg::*;

	localparam int SW    = (MAX_SITES > COL_W) ? MAX_SITES : COL_W;
	localparam int CNT_W = $clog2(MAX_SITES + 1);
	localparam int HW    = CNT_W + 2;

	logic [NSITE_W-1:0]       len, nb;
	logic [SW-1:0]            rowx;
	logic                     row_err;
	logic [MAX_SITES-1:0]     anti, active, lmask, flip_v, bond_v;
	logic [CNT_W-1:0]         ones, antic;
	logic signed [VAL_W-1:0]  pair_sum, pair_dif;
	logic                     sum_nz, dif_nz;
	logic signed [HW-1:0]     hz, hb;

	logic                     valid_s1;
	logic [COL_W-1:0]         row_s1;
	logic                     err_s1;
	logic [MAX_SITES-1:0]     flip_s1, bond_s1, anti_s1;
	logic signed [HW-1:0]     hz_s1, hb_s1;

	logic signed [HW+COEF_W-1:0] prod_z, prod_b;
	logic signed [VAL_W-1:0]     diag;

	always_comb begin
		int nxt;
		len      = clamp_len(cfg.num_sites, NSITE_W'(MAX_SITES));
		nb       = cfg.open_boundary ? len - NSITE_W'(1) : len;
		rowx     = SW'(s_axis_tdata);
		row_err  = (rowx >> len) != '0;
		pair_sum = VAL_W'(cfg.coupling_x) + VAL_W'(cfg.coupling_y);
		pair_dif = VAL_W'(cfg.coupling_x) - VAL_W'(cfg.coupling_y);
		sum_nz   = pair_sum != '0;
		dif_nz   = pair_dif != '0;
		ones     = '0;
		antic    = '0;
		for (int i = 0; i < MAX_SITES; i++) begin
			// bond i joins site i to the next one, wrapping to site 0
			nxt       = (i + 1 >= int'(len)) ? 0 : i + 1;
			lmask[i]  = i < int'(len);
			active[i] = i < int'(nb);
			anti[i]   = rowx[i] ^ rowx[nxt];
			if (lmask[i] && rowx[i]) ones = ones + CNT_W'(1);
			if (active[i] && anti[i]) antic = antic + CNT_W'(1);
		end
		flip_v = (cfg.field_x != '0) ? lmask : '0;
		bond_v = active & ((anti & {MAX_SITES{sum_nz}}) | (~anti & {MAX_SITES{dif_nz}}));
		hz     = $signed(HW'(nb)) - $signed(HW'({antic, 1'b0}));
		hb     = $signed(HW'({ones, 1'b0})) - $signed(HW'(len));
	end

	assign s_axis_tready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			row_s1  <= s_axis_tdata;
			err_s1  <= row_err;
			flip_s1 <= flip_v;
			bond_s1 <= bond_v;
			anti_s1 <= anti;
			hz_s1   <= hz;
			hb_s1   <= hb;
		end
	end

	assign prod_z = hz_s1 * cfg.coupling_z;
	assign prod_b = hb_s1 * cfg.field_z;
	assign diag   = VAL_W'(prod_z) + VAL_W'(prod_b);

	assign push_valid = valid_s1;
	assign push_data  = {anti_s1, bond_s1, flip_s1, diag != '0, diag, err_s1, row_s1};

endmodule

@@ hw/rtl/shc_back.sv @@
module shc_back #(
	parameter int MAX_SITES = shc_pkg::DEF_MAX_SITES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  shc_pkg::cfg_t                        cfg,
	input  logic                                 pop_valid,
	output logic                                 pop_ready,
	input  logic [shc_pkg::entry_w(MAX_SITES)-1:0] pop_data,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [shc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // column_index, entry_value
	output logic [shc_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,   // entry_valid, row_error
	output logic                                 m_axis_tlast
);

	import shc_pkg::*;

	localparam int SW = (MAX_SITES > COL_W) ? MAX_SITES : COL_W;
	localparam int LW = $clog2(MAX_SITES);

	// item being expanded
	logic                    work_valid_q;
	logic [COL_W-1:0]        row_q;
	logic                    mark_q, err_q;
	logic signed [VAL_W-1:0] diag_q;
	logic                    diag_en_q;
	logic [MAX_SITES-1:0]    flip_q, bond_q, anti_q;

	// output register
	logic                    out_valid_q;
	logic [COL_W-1:0]        ocol_q;
	logic signed [VAL_W-1:0] oval_q;
	logic                    oent_q, oerr_q, olast_q;

	logic                    ld_err, ld_den;
	logic [MAX_SITES-1:0]    ld_flip, ld_bond;
	logic [NSITE_W-1:0]      len, nxt;
	logic [LW-1:0]           flip_idx, bond_idx;
	logic [SW-1:0]           rowx, colx;
	logic signed [VAL_W-1:0] pair_sum, pair_dif;
	logic                    rem_diag;
	logic [MAX_SITES-1:0]    rem_flip, rem_bond;
	logic [COL_W-1:0]        n_col;
	logic signed [VAL_W-1:0] n_val;
	logic                    last, emit;

	assign ld_err  = pop_data[OFS_ERR];
	assign ld_den  = pop_data[OFS_DEN];
	assign ld_flip = pop_data[OFS_VEC +: MAX_SITES];
	assign ld_bond = pop_data[OFS_VEC + MAX_SITES +: MAX_SITES];

	always_comb begin
		len      = clamp_len(cfg.num_sites, NSITE_W'(MAX_SITES));
		pair_sum = VAL_W'(cfg.coupling_x) + VAL_W'(cfg.coupling_y);
		pair_dif = VAL_W'(cfg.coupling_x) - VAL_W'(cfg.coupling_y);
		rowx     = SW'(row_q);
		flip_idx = '0;
		bond_idx = '0;
		for (int i = MAX_SITES - 1; i >= 0; i--) begin
			if (flip_q[i]) flip_idx = LW'(i);
			if (bond_q[i]) bond_idx = LW'(i);
		end
		nxt = (NSITE_W'(bond_idx) + NSITE_W'(1) >= len) ? '0
			: NSITE_W'(bond_idx) + NSITE_W'(1);

		rem_diag = diag_en_q;
		rem_flip = flip_q;
		rem_bond = bond_q;
		colx     = rowx;
		n_val    = diag_q;
		if (diag_en_q) begin
			rem_diag = 1'b0;
		end else if (flip_q != '0) begin
			rem_flip = flip_q & ~(MAX_SITES'(1) << flip_idx);
			colx     = rowx ^ (SW'(1) << flip_idx);
			n_val    = VAL_W'(cfg.field_x);
		end else begin
			rem_bond = bond_q & ~(MAX_SITES'(1) << bond_idx);
			colx     = rowx ^ ((SW'(1) << bond_idx) | (SW'(1) << nxt));
			n_val    = anti_q[bond_idx] ? pair_sum : pair_dif;
		end
		n_col = colx[COL_W-1:0];
		last  = mark_q || !(rem_diag || rem_flip != '0 || rem_bond != '0);
	end

	assign emit      = work_valid_q && (!out_valid_q || m_axis_tready);
	assign pop_ready = !work_valid_q || (emit && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) work_valid_q <= 1'b1;
			else if (emit && last) work_valid_q <= 1'b0;
			if (emit) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			row_q     <= pop_data[COL_W-1:0];
			err_q     <= ld_err;
			// error or nothing to emit: one marker word
			mark_q    <= ld_err || !(ld_den || ld_flip != '0 || ld_bond != '0);
			diag_q    <= pop_data[OFS_DIAG +: VAL_W];
			diag_en_q <= ld_den;
			flip_q    <= ld_flip;
			bond_q    <= ld_bond;
			anti_q    <= pop_data[OFS_VEC + 2 * MAX_SITES +: MAX_SITES];
		end else if (emit) begin
			diag_en_q <= rem_diag;
			flip_q    <= rem_flip;
			bond_q    <= rem_bond;
		end
		if (emit) begin
			ocol_q  <= mark_q ? '0 : n_col;
			oval_q  <= mark_q ? '0 : n_val;
			oent_q  <= !mark_q;
			oerr_q  <= mark_q && err_q;
			olast_q <= last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - COL_W - VAL_W){1'b0}}, oval_q, ocol_q};
	assign m_axis_tuser  = {oerr_q, oent_q};
	assign m_axis_tlast  = olast_q;

endmodule

@@ dv/spin_chain_hamiltonian_row_gen_test.sv @@
`timescale 1ns / 100ps

module spin_chain_hamiltonian_row_gen_test;
	import shc_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int MAX_L      = DEF_MAX_SITES;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] val;
		logic             ent;
		logic             err;
		logic             last;
	} entry_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [COL_W-1:0]       s_axis_tdata  = '0;   // row_index
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;         // column_index, entry_value
	logic [OUT_TUSER_W-1:0] m_axis_tuser;         // entry_valid, row_error
	logic                   m_axis_tlast;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;

	entry_t pending_entries[$];
	cfg_t   model_cfg;
	int     mismatch_count = 0;
	int     idle_cycles    = 0;
	int     burst_left     = 0;
	int     ready_mode     = 0;
	int     ready_tick     = 0;

	spin_chain_hamiltonian_row_gen u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// receiver switches between always ready, light, heavy and periodic stalls
	always @(posedge clk) begin
		if (ready_tick == 0) begin
			ready_mode <= $urandom_range(0, 3);
			ready_tick <= $urandom_range(20, 80);
		end else begin
			ready_tick <= ready_tick - 1;
		end
		case (ready_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= ((ready_tick % 7) < 3);
		endcase
	end

	function automatic int site_count(input logic [NSITE_W-1:0] n);
		int len;
		len = int'(n);
		if (len < 1) len = 1;
		if (len > MAX_L) len = MAX_L;
		return len;
	endfunction

	// the two sites joined by bond l; on a one-site ring both ends are site 0
	function automatic logic [COL_W-1:0] bond_sites(input int l, input int len);
		int nxt;
		nxt = (l + 1 >= len) ? 0 : l + 1;
		return COL_W'((1 << l) | (1 << nxt));
	endfunction

	function automatic bit is_antiparallel(input logic [COL_W-1:0] row,
		input logic [COL_W-1:0] m);
		logic [COL_W-1:0] v;
		v = row & m;
		return (v != '0) && (v != m);
	endfunction

	task automatic predict_row_entries(input logic [COL_W-1:0] row);
		int               len;
		int               bonds;
		int               hz;
		int               hb;
		int               diag;
		int               pair;
		logic [COL_W-1:0] m;
		entry_t           e;
		entry_t           found[$];
		len   = site_count(model_cfg.num_sites);
		bonds = model_cfg.open_boundary ? len - 1 : len;
		e     = '0;
		if (int'(row) >= (1 << len)) begin
			e.err  = 1'b1;
			e.last = 1'b1;
			pending_entries.push_back(e);
			return;
		end
		hz = 0;
		hb = 0;
		for (int l = 0; l < len; l++)
			hb += row[l] ? 1 : -1;
		for (int l = 0; l < bonds; l++)
			hz += is_antiparallel(row, bond_sites(l, len)) ? -1 : 1;
		diag = hz * int'(model_cfg.coupling_z) + hb * int'(model_cfg.field_z);
		if (diag != 0) begin
			e     = '0;
			e.col = row;
			e.val = VAL_W'(diag);
			e.ent = 1'b1;
			found.push_back(e);
		end
		if (model_cfg.field_x != '0) begin
			for (int l = 0; l < len; l++) begin
				e     = '0;
				e.col = row ^ COL_W'(1 << l);
				e.val = VAL_W'(int'(model_cfg.field_x));
				e.ent = 1'b1;
				found.push_back(e);
			end
		end
		for (int l = 0; l < bonds; l++) begin
			m = bond_sites(l, len);
			if (is_antiparallel(row, m))
				pair = int'(model_cfg.coupling_x) + int'(model_cfg.coupling_y);
			else
				pair = int'(model_cfg.coupling_x) - int'(model_cfg.coupling_y);
			if (pair != 0) begin
				e     = '0;
				e.col = row ^ m;
				e.val = VAL_W'(pair);
				e.ent = 1'b1;
				found.push_back(e);
			end
		end
		if (found.size() == 0) begin
			e      = '0;
			e.last = 1'b1;
			pending_entries.push_back(e);
		end else begin
			foreach (found[i]) begin
				e      = found[i];
				e.last = (i == found.size() - 1);
				pending_entries.push_back(e);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t %s: got %0h want %0h", $time, what, got, want);
	endtask

	always @(posedge clk) begin : watch_ports
		entry_t want;
		if (!arst_n) begin
			model_cfg = make_cfg(int'(RST_NUM_SITES), 0, int'(RST_COEF), int'(RST_COEF),
				int'(RST_COEF), int'(RST_COEF), int'(RST_COEF));
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_NUM_SITES:     model_cfg.num_sites     = cfg_data[NSITE_W-1:0];
					REG_OPEN_BOUNDARY: model_cfg.open_boundary = cfg_data[0];
					REG_COUPLING_X:    model_cfg.coupling_x    = cfg_data;
					REG_COUPLING_Y:    model_cfg.coupling_y    = cfg_data;
					REG_COUPLING_Z:    model_cfg.coupling_z    = cfg_data;
					REG_FIELD_X:       model_cfg.field_x       = cfg_data;
					REG_FIELD_Z:       model_cfg.field_z       = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_row_entries(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_entries.size() == 0) begin
					report_mismatch("word with nothing expected",
						int'(m_axis_tdata[COL_W-1:0]), 0);
				end else begin
					want = pending_entries.pop_front();
					if (m_axis_tdata[COL_W-1:0] !== want.col)
						report_mismatch("column_index", int'(m_axis_tdata[COL_W-1:0]),
							int'(want.col));
					if (m_axis_tdata[COL_W +: VAL_W] !== want.val)
						report_mismatch("entry_value", int'(m_axis_tdata[COL_W +: VAL_W]),
							int'(want.val));
					if (m_axis_tuser[0] !== want.ent)
						report_mismatch("entry_valid", int'(m_axis_tuser[0]), int'(want.ent));
					if (m_axis_tuser[1] !== want.err)
						report_mismatch("row_error", int'(m_axis_tuser[1]), int'(want.err));
					if (m_axis_tlast !== want.last)
						report_mismatch("last_entry", int'(m_axis_tlast), int'(want.last));
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		@(negedge clk);
		while (idle_cycles < IDLE_LIMIT) @(negedge clk);
		$display("spin_chain_hamiltonian_row_gen: mismatch");
		$finish;
	end

	task automatic send_row(input logic [COL_W-1:0] row);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= row;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
	endtask

	// hold the sender until every expected word has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_entries.size() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		wait_drained();
		write_reg(REG_NUM_SITES, CFG_DATA_W'(c.num_sites));
		write_reg(REG_OPEN_BOUNDARY, CFG_DATA_W'(c.open_boundary));
		write_reg(REG_COUPLING_X, c.coupling_x);
		write_reg(REG_COUPLING_Y, c.coupling_y);
		write_reg(REG_COUPLING_Z, c.coupling_z);
		write_reg(REG_FIELD_X, c.field_x);
		write_reg(REG_FIELD_Z, c.field_z);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic cfg_t make_cfg(input int n, input int ob, input int jx, input int jy,
		input int jz, input int bx, input int bz);
		cfg_t c;
		c.num_sites     = NSITE_W'(n);
		c.open_boundary = ob[0];
		c.coupling_x    = COEF_W'(jx);
		c.coupling_y    = COEF_W'(jy);
		c.coupling_z    = COEF_W'(jz);
		c.field_x       = COEF_W'(bx);
		c.field_z       = COEF_W'(bz);
		return c;
	endfunction

	function automatic logic [COEF_W-1:0] random_coef();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'h8000;
			2: return 16'h7FFF;
			3: return COEF_W'($urandom_range(0, 8) - 4);
			default: return COEF_W'($urandom);
		endcase
	endfunction

	// one-site ring after reset, rows past the end give the error word
	task automatic test_reset_defaults();
		send_row(16'h0000);
		send_row(16'h0001);
		send_row(16'h0002);
		send_row(16'hFFFF);
	endtask

	// longest rows with the extreme coefficients
	task automatic test_full_chain();
		load_config(make_cfg(16, 0, 32767, -32768, -32768, -32768, 32767));
		send_row(16'h0000);
		send_row(16'hFFFF);
		send_row(16'hAAAA);
		send_row(16'h5555);
		send_row(16'h8001);
	endtask

	// two-site ring has both bonds on the same pair; open chain keeps one
	task automatic test_two_sites();
		load_config(make_cfg(2, 0, 300, -100, 77, 0, -5));
		for (int r = 0; r < 5; r++)
			send_row(COL_W'(r));
		load_config(make_cfg(2, 1, 300, -100, 77, 0, -5));
		send_row(16'h0001);
		send_row(16'h0002);
	endtask

	task automatic test_clamped_length();
		load_config(make_cfg(0, 0, 256, 128, -64, 1, 3));
		send_row(16'h0000);
		send_row(16'h0001);
		send_row(16'h0002);
		load_config(make_cfg(31, 1, 256, 128, -64, 1, 3));
		send_row(16'hFFFF);
		send_row(16'h1234);
	endtask

	// all-zero coefficients, then jx = jy so only antiparallel bonds remain
	task automatic test_empty_rows();
		load_config(make_cfg(3, 0, 0, 0, 0, 0, 0));
		send_row(16'h0000);
		send_row(16'h0005);
		load_config(make_cfg(3, 1, 100, 100, 0, 0, 0));
		send_row(16'h0000);
		send_row(16'h0002);
	endtask

	task automatic test_random_rows();
		cfg_t             c;
		int               len;
		int               count;
		logic [COL_W-1:0] mask;
		logic [COL_W-1:0] row;
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 9))
				0: c.num_sites = '0;
				1: c.num_sites = NSITE_W'($urandom_range(17, 31));
				2: c.num_sites = NSITE_W'(16);
				default: c.num_sites = NSITE_W'($urandom_range(1, 16));
			endcase
			if (ph == 0)
				c.num_sites = NSITE_W'(16);
			c.open_boundary = 1'($urandom_range(0, 1));
			c.coupling_x    = random_coef();
			case ($urandom_range(0, 3))
				0: c.coupling_y = c.coupling_x;
				1: c.coupling_y = -c.coupling_x;
				default: c.coupling_y = random_coef();
			endcase
			c.coupling_z = random_coef();
			c.field_x    = random_coef();
			c.field_z    = random_coef();
			load_config(c);
			len   = site_count(c.num_sites);
			mask  = COL_W'((1 << len) - 1);
			count = $urandom_range(42, 52);
			for (int i = 0; i < count; i++) begin
				case ($urandom_range(0, 9))
					0: row = COL_W'($urandom_range(0, 65535));
					1: row = mask;
					2: row = '0;
					3: row = 16'h5555 & mask;
					default: row = COL_W'($urandom) & mask;
				endcase
				send_row(row);
				if ($urandom_range(0, 39) == 0)
					wait_drained();
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_full_chain();
		test_two_sites();
		test_clamped_length();
		test_empty_rows();
		test_random_rows();
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("spin_chain_hamiltonian_row_gen: match");
		else
			$display("spin_chain_hamiltonian_row_gen: mismatch");
		$finish;
	end

endmodule
